FILE: rtl/histogram_percentile_edge_quantizer_defines.svh
// ----------------------------------------------------------------------------
// Histogram percentile edge quantizer: assertion macros
// Shared macros for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_PERCENTILE_EDGE_QUANTIZER_DEFINES_SVH
`define HISTOGRAM_PERCENTILE_EDGE_QUANTIZER_DEFINES_SVH

// Concurrent check on a given clock, disabled while the active-low reset is low.
`define HPEQ_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Same check on the block's own clk and rst_n.
`define HPEQ_CHK(lbl, prop, msg) \
  `HPEQ_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

FILE: rtl/hpeq_pkg.sv
// ----------------------------------------------------------------------------
// hpeq_pkg
// Types and constants of the histogram percentile edge quantizer.
// ----------------------------------------------------------------------------
package hpeq_pkg;

  localparam int HIST_W   = 21;
  localparam int NBINS    = 256;
  localparam int BIN_AW   = 8;
  localparam int NBOUNDS  = 17;
  localparam int BND_W    = 10;
  localparam int SUM_W    = 29;
  localparam int A10_W    = 34;
  localparam int A100_W   = 36;
  localparam int NUM_W    = 10;
  localparam int DEN_W    = 5;

  localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};

  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_FINAL = 2'd1;
  localparam logic [1:0] CMD_LABEL = 2'd2;

  localparam logic KIND_LABEL = 1'b0;
  localparam logic KIND_THRESH = 1'b1;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_NOP,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_SUM_RD,
    ST_SUM_AC,
    ST_CALC,
    ST_SCAN_RD,
    ST_SCAN_AC,
    ST_LOW,
    ST_DIV,
    ST_BND_INIT,
    ST_BND,
    ST_LAB_CMP,
    ST_LAB_ENC,
    ST_EMIT
  } hpeq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hpeq_div_stat_t;

endpackage

FILE: rtl/hpeq_ram.sv
// ----------------------------------------------------------------------------
// hpeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hpeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hpeq_div.sv
// ----------------------------------------------------------------------------
// hpeq_div
// Restoring divider, one quotient bit per cycle, for the bound step size.
// ----------------------------------------------------------------------------
module hpeq_div
  import hpeq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output hpeq_div_stat_t   stat
);

  logic [NUM_W-1:0] quot_r;
  logic [NUM_W-1:0] shf_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [3:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, shf_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shf_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      shf_r  <= {shf_r[NUM_W-2:0], 1'b0};
      rem_r  <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quot_r <= {quot_r[NUM_W-2:0], fits};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/histogram_percentile_edge_quantizer.sv
// Count: each word reads its bin and writes it back plus one, saturating at the maximum;
// a zero gradient or an unused command goes through a no-op state. Label: the word is
// compared with the bounds, the hit is encoded and the result waits until the output
// register takes it. Finalize: two sweeps over 256 bins, a divide and up to 14 bound steps.
// After reset a clearing sweep over all 256 bins zeroes the histogram; in_tready
// stays low until it is done. Reset is synchronous, active low.
module histogram_percentile_edge_quantizer
  import hpeq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,      // num_edges
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // gradient[7:0]
  input  logic [1:0]  in_tuser,       // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,      // label[4:0], lower_bound[12:5], upper_bound[20:13], zero
  output logic [0:0]  out_tuser       // result_kind[0]
);

  hpeq_state_t state_r, state_nxt;

  logic [3:0]        num_edges_r;
  logic [8:0]        k_r;
  logic [7:0]        g_r;
  logic [SUM_W-1:0]  sum_r;
  logic [A10_W-1:0]  x_r, a10_r, a10_nxt;
  logic [A100_W-1:0] y_r, c100_r, c100_nxt;
  logic              found_r;
  logic [7:0]        up_r, lo_r;
  logic [8:0]        cnt_r;
  logic [3:0]        n_r, n_lat_r;
  logic [BND_W-1:0]  bnd_r [NBOUNDS];
  logic [3:0]        jb_r;
  logic [BND_W-1:0]  acc_r;
  logic [15:0]       hit_r;
  logic              res_kind_r;
  logic [4:0]        res_label_r;
  logic [7:0]        res_lo_r, res_up_r;
  logic              out_valid_r;
  logic              out_kind_r;
  logic [4:0]        out_label_r;
  logic [7:0]        out_lo_r, out_up_r;

  logic              ram_we;
  logic [BIN_AW-1:0] ram_waddr, ram_raddr;
  logic [HIST_W-1:0] ram_wdata, ram_rdata;

  logic              div_start;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]  div_den;
  hpeq_div_stat_t    div_stat;

  logic [24:0]       h10;
  logic [27:0]       h100;
  logic [3:0]        n_eff, m_eff;
  logic [7:0]        low_cnt, low_pick;
  logic [10:0]       num_wide;
  logic [4:0]        lab_enc;
  logic              out_load;

  hpeq_ram #(.WIDTH(HIST_W), .DEPTH(NBINS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hpeq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Times ten and times one hundred by shifts and adds; bin zero never counts.
  always_comb begin
    logic [HIST_W-1:0] h;
    h        = (k_r == 9'd0) ? '0 : ram_rdata;
    h10      = 25'({h, 3'b000}) + 25'({h, 1'b0});
    h100     = 28'({h, 6'b0}) + 28'({h, 5'b0}) + 28'({h, 2'b00});
    a10_nxt  = a10_r + A10_W'(h10);
    c100_nxt = c100_r + A100_W'(h100);
  end

  assign n_eff    = (num_edges_r == 4'd0) ? 4'd1 : num_edges_r;
  assign m_eff    = n_r - 4'd1;
  assign low_cnt  = 8'(cnt_r - 9'd1);
  assign low_pick = (low_cnt < up_r) ? low_cnt : up_r;
  assign num_wide = {2'b00, up_r, 1'b0} + {7'd0, m_eff} - {2'b00, lo_r, 1'b0};
  assign div_num  = num_wide[NUM_W-1:0];
  assign div_den  = {m_eff, 1'b0};

  always_comb begin
    lab_enc = 5'd0;
    for (int j = 0; j < 16; j++) begin
      if (hit_r[j]) begin
        lab_enc = 5'(j + 1);
      end
    end
  end

  assign out_load = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = k_r[BIN_AW-1:0];
    ram_wdata = '0;
    ram_raddr = k_r[BIN_AW-1:0];
    div_start = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        ram_we = 1'b1;
        if (k_r == 9'd255) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            CMD_COUNT: state_nxt = (in_tdata != 8'd0) ? ST_CNT_RD : ST_NOP;
            CMD_FINAL: state_nxt = ST_SUM_RD;
            CMD_LABEL: state_nxt = ST_LAB_CMP;
            default:   state_nxt = ST_NOP;
          endcase
        end
      end
      ST_NOP: state_nxt = ST_IDLE;
      ST_CNT_RD: begin
        ram_raddr = g_r;
        state_nxt = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        ram_we    = ram_rdata != HIST_MAX;
        ram_waddr = g_r;
        ram_wdata = ram_rdata + HIST_W'(1);
        state_nxt = ST_IDLE;
      end
      ST_SUM_RD: state_nxt = ST_SUM_AC;
      ST_SUM_AC: state_nxt = (k_r == 9'd255) ? ST_CALC : ST_SUM_RD;
      ST_CALC:   state_nxt = ST_SCAN_RD;
      ST_SCAN_RD: state_nxt = ST_SCAN_AC;
      ST_SCAN_AC: begin
        // The second sweep also clears the histogram behind it.
        ram_we = 1'b1;
        if (k_r == 9'd255) begin
          state_nxt = ST_LOW;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_LOW: state_nxt = ST_DIV;
      ST_DIV: begin
        if (n_r < 4'd2) begin
          state_nxt = ST_BND_INIT;
        end else if (!div_stat.busy && !div_stat.done) begin
          div_start = 1'b1;
        end else if (div_stat.done) begin
          state_nxt = ST_BND_INIT;
        end
      end
      ST_BND_INIT: state_nxt = ST_BND;
      ST_BND:      state_nxt = (jb_r < n_r) ? ST_BND : ST_EMIT;
      ST_LAB_CMP:  state_nxt = ST_LAB_ENC;
      ST_LAB_ENC:  state_nxt = ST_EMIT;
      ST_EMIT:     state_nxt = out_load ? ST_IDLE : ST_EMIT;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      k_r         <= '0;
      num_edges_r <= 4'd2;
      n_lat_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NBOUNDS; i++) begin
        bnd_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        num_edges_r <= cfg_wdata;
      end
      if (state_r == ST_EMIT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR:    k_r <= k_r + 9'd1;
        ST_IDLE:   k_r <= '0;
        ST_SUM_AC: k_r <= (k_r == 9'd255) ? 9'd0 : k_r + 9'd1;
        ST_SCAN_AC: k_r <= k_r + 9'd1;
        ST_BND_INIT: begin
          for (int i = 0; i < NBOUNDS; i++) begin
            if (5'(i) == 5'(n_r) + 5'd1) begin
              bnd_r[i] <= BND_W'(255);
            end else if (i == 1) begin
              bnd_r[i] <= (n_r >= 4'd2) ? BND_W'(lo_r) : BND_W'(128);
            end else if (5'(i) == 5'(n_r) && n_r >= 4'd2) begin
              bnd_r[i] <= BND_W'(up_r);
            end else begin
              bnd_r[i] <= '0;
            end
          end
        end
        ST_BND: begin
          if (jb_r < n_r) begin
            bnd_r[5'(jb_r)] <= acc_r + div_quot;
          end else begin
            n_lat_r <= n_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        g_r     <= in_tdata;
        sum_r   <= '0;
        a10_r   <= A10_W'(10);
        c100_r  <= '0;
        found_r <= 1'b0;
        cnt_r   <= '0;
      end
      ST_SUM_AC: sum_r <= sum_r + SUM_W'((k_r == 9'd0) ? '0 : ram_rdata);
      ST_CALC: begin
        x_r <= A10_W'({sum_r, 3'b000}) + A10_W'(sum_r) + A10_W'(5);
        y_r <= A100_W'({sum_r, 4'b0000}) - A100_W'(sum_r) + A100_W'(50);
      end
      ST_SCAN_AC: begin
        a10_r  <= a10_nxt;
        c100_r <= c100_nxt;
        // First bin from two on whose running count reaches the 90 percent mark.
        if (!found_r && k_r >= 9'd2 && a10_nxt > x_r) begin
          found_r <= 1'b1;
          up_r    <= 8'(k_r - 9'd1);
        end
        if (c100_nxt <= y_r) begin
          cnt_r <= cnt_r + 9'd1;
        end
      end
      ST_LOW: begin
        n_r <= n_eff;
        if (sum_r == '0) begin
          up_r <= 8'd0;
          lo_r <= 8'd1;
        end else begin
          lo_r <= low_pick + 8'd1;
        end
      end
      ST_BND_INIT: begin
        acc_r <= BND_W'(lo_r);
        jb_r  <= 4'd2;
      end
      ST_BND: begin
        if (jb_r < n_r) begin
          acc_r <= acc_r + div_quot;
          jb_r  <= jb_r + 4'd1;
        end else begin
          res_kind_r  <= KIND_THRESH;
          res_label_r <= 5'd0;
          res_lo_r    <= lo_r;
          res_up_r    <= up_r;
        end
      end
      ST_LAB_CMP: begin
        for (int j = 0; j < 16; j++) begin
          hit_r[j] <= ({2'b00, g_r} > bnd_r[j]) && ({2'b00, g_r} <= bnd_r[j+1]) &&
                      (4'(j) <= n_lat_r) && (n_lat_r != 4'd0);
        end
      end
      ST_LAB_ENC: begin
        res_kind_r  <= KIND_LABEL;
        res_label_r <= lab_enc;
        res_lo_r    <= 8'd0;
        res_up_r    <= 8'd0;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_kind_r  <= res_kind_r;
          out_label_r <= res_label_r;
          out_lo_r    <= res_lo_r;
          out_up_r    <= res_up_r;
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_up_r, out_lo_r, out_label_r};
  assign out_tuser  = out_kind_r;

endmodule

FILE: rtl/hpeq_checker.sv
// ----------------------------------------------------------------------------
// hpeq_checker
// Port-level checks of the histogram percentile edge quantizer.
// ----------------------------------------------------------------------------
`include "histogram_percentile_edge_quantizer_defines.svh"

module hpeq_checker
  import hpeq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser
);

  `HPEQ_CHK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result word dropped while stalled")
  `HPEQ_CHK(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "input taken while a word is in work")
  `HPEQ_CHK(a_thresh_no_label, out_tvalid && out_tuser[0] == KIND_THRESH |-> out_tdata[4:0] == 5'd0, "threshold word with a label")
  `HPEQ_CHK(a_label_word, out_tvalid && out_tuser[0] == KIND_LABEL |-> out_tdata[23:5] == 19'd0 && out_tdata[4:0] <= 5'd16, "malformed label word")

endmodule

bind histogram_percentile_edge_quantizer hpeq_checker u_hpeq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
